[hw/rtl/assert_macros.svh]
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed");

// Condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

[hw/rtl/rdqg_pkg.sv]
`timescale 1ns / 1ps

package rdqg_pkg;

  localparam int MAX_CHANNELS_DEF = 1024;

  localparam int VAL_W    = 24;  // Q8.16 value, error, reference
  localparam int TOL_W    = 23;
  localparam int FRAC_W   = 17;  // 65536 = 1.0
  localparam int FRAC_BITS = 16;
  localparam int SUM_W    = 35;
  localparam int CNT_W    = 11;  // count fields of a result
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int STEP_W   = $clog2(SUM_W);

  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_GOOD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_MEDIUM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_OVERLAP  = 3'd4;

  localparam logic [VAL_W-1:0]  RESET_REFERENCE   = 24'd65536;
  localparam logic [TOL_W-1:0]  RESET_TOLERANCE   = 23'd6554;
  localparam logic [FRAC_W-1:0] RESET_FRAC_GOOD   = 17'd58982;
  localparam logic [FRAC_W-1:0] RESET_FRAC_MEDIUM = 17'd45875;

  typedef enum logic [1:0] {
    GRADE_NULL   = 2'd0,
    GRADE_GOOD   = 2'd1,
    GRADE_MEDIUM = 2'd2,
    GRADE_BAD    = 2'd3
  } grade_t;

  typedef enum logic [2:0] {
    REASON_NONE         = 3'd0,
    REASON_NO_VALID     = 3'd1,
    REASON_BELOW_MEDIUM = 3'd2,
    REASON_BELOW_GOOD   = 3'd3,
    REASON_LOW_OVERLAP  = 3'd4
  } reason_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] reference;
    logic [TOL_W-1:0]        tolerance;
    logic [FRAC_W-1:0]       frac_good;
    logic [FRAC_W-1:0]       frac_medium;
    logic                    require_overlap;
  } cfg_regs_t;

  typedef struct packed {
    logic accum;     // take one point into the accumulators
    logic load;      // register threshold products, start divider
    logic div_step;  // one quotient bit
    logic finish;    // load result register, clear accumulators
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/rdqg_ctrl.sv]
`timescale 1ns / 1ps

module rdqg_ctrl
  import rdqg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  input  stat_t stat,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_RUN,
    S_PROD,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;
  logic [STEP_W-1:0] step;

  always_comb begin
    cmd.accum    = in_ready && in_valid;
    cmd.load     = (state == S_PROD);
    cmd.div_step = (state == S_DIV);
    cmd.finish   = (state == S_DONE) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RUN;
      in_ready <= 1'b1;
      step     <= '0;
    end else begin
      unique case (state)
        S_RUN: begin
          if (in_valid && in_ready && in_last) begin
            state    <= S_PROD;
            in_ready <= 1'b0;
          end
        end
        S_PROD: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= S_DONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DONE: begin
          if (stat.out_free) begin
            state    <= S_RUN;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_RUN;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

[hw/rtl/rdqg_datapath.sv]
`timescale 1ns / 1ps

module rdqg_datapath
  import rdqg_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  cfg_regs_t               cfg,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic signed [VAL_W-1:0] in_error,
  input  logic                    in_not_a_number,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_grade,
  output logic [2:0]              out_reason_code,
  output logic [CNT_W-1:0]        out_valid_count,
  output logic [CNT_W-1:0]        out_inside_count,
  output logic [CNT_W-1:0]        out_overlap_count,
  output logic [VAL_W-1:0]        out_mean_deviation,
  output logic [VAL_W-1:0]        out_max_deviation
);

  localparam int TW = $clog2(MAX_CHANNELS + 1);
  localparam int PW = FRAC_W + TW;

  logic [TW-1:0]    valid_tally;
  logic [TW-1:0]    inside_tally;
  logic [TW-1:0]    overlap_tally;
  logic [SUM_W-1:0] deviation_sum;
  logic [VAL_W-1:0] deviation_peak;

  logic [PW-1:0]    prod_medium;
  logic [PW-1:0]    prod_good;
  logic [SUM_W-1:0] quo;
  logic [TW-1:0]    rem;

  logic             point_ok;
  logic [VAL_W:0]   diff;
  logic [VAL_W-1:0] dev;
  logic [VAL_W:0]   inside_limit;
  logic [SUM_W:0]   sum_next;
  logic [TW:0]      rem_shift;
  logic             rem_ge;

  logic             below_medium;
  logic             below_good;
  logic             overlap_low;
  grade_t           grade_next;
  reason_t          reason_next;
  logic [VAL_W-1:0] mean_next;

  assign stat.out_free = !out_valid || out_ready;

  // Point datapath: |value - reference| and the two window tests.
  always_comb begin
    point_ok = !in_not_a_number && !in_error[VAL_W-1] && (|in_error)
               && (valid_tally < TW'(MAX_CHANNELS));
    diff = {in_value[VAL_W-1], in_value} - {cfg.reference[VAL_W-1], cfg.reference};
    dev  = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
    // error is positive here
    inside_limit = {2'b00, cfg.tolerance} + {1'b0, in_error};
    sum_next = {1'b0, deviation_sum} + {{(SUM_W + 1 - VAL_W){1'b0}}, dev};
  end

  // Restoring divider step
  always_comb begin
    rem_shift = {rem, quo[SUM_W-1]};
    rem_ge    = rem_shift >= {1'b0, valid_tally};
  end

  always_comb begin
    below_medium = PW'({inside_tally, {FRAC_BITS{1'b0}}}) < prod_medium;
    below_good   = PW'({inside_tally, {FRAC_BITS{1'b0}}}) < prod_good;
    overlap_low  = PW'({overlap_tally, {FRAC_BITS{1'b0}}}) < prod_good;
    if (valid_tally == '0) begin
      mean_next = '0;
    end else if (|quo[SUM_W-1:VAL_W]) begin
      mean_next = '1;
    end else begin
      mean_next = quo[VAL_W-1:0];
    end
    priority if (valid_tally == '0) begin
      grade_next  = GRADE_NULL;
      reason_next = REASON_NO_VALID;
    end else if (below_medium) begin
      grade_next  = GRADE_BAD;
      reason_next = REASON_BELOW_MEDIUM;
    end else if (below_good) begin
      grade_next  = GRADE_MEDIUM;
      reason_next = REASON_BELOW_GOOD;
    end else if (cfg.require_overlap && overlap_low) begin
      grade_next  = GRADE_MEDIUM;
      reason_next = REASON_LOW_OVERLAP;
    end else begin
      grade_next  = GRADE_GOOD;
      reason_next = REASON_NONE;
    end
  end

  // Accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      valid_tally    <= '0;
      inside_tally   <= '0;
      overlap_tally  <= '0;
      deviation_sum  <= '0;
      deviation_peak <= '0;
    end else if (cmd.accum && point_ok) begin
      valid_tally   <= valid_tally + 1'b1;
      deviation_sum <= sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
      if (dev > deviation_peak) begin
        deviation_peak <= dev;
      end
      if ({1'b0, dev} <= inside_limit) begin
        inside_tally <= inside_tally + 1'b1;
      end
      if (dev <= in_error) begin
        overlap_tally <= overlap_tally + 1'b1;
      end
    end
  end

  // Threshold products and divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod_medium <= cfg.frac_medium * valid_tally;
      prod_good   <= cfg.frac_good * valid_tally;
      quo         <= deviation_sum;
      rem         <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[SUM_W-2:0], rem_ge};
      rem <= rem_ge ? TW'(rem_shift - {1'b0, valid_tally}) : rem_shift[TW-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_grade          <= grade_next;
      out_reason_code    <= reason_next;
      out_valid_count    <= CNT_W'(valid_tally);
      out_inside_count   <= CNT_W'(inside_tally);
      out_overlap_count  <= CNT_W'(overlap_tally);
      out_mean_deviation <= mean_next;
      out_max_deviation  <= deviation_peak;
    end
  end

endmodule

[hw/rtl/reference_deviation_quality_grader.sv]
`timescale 1ns / 1ps

// Grades a set of Q8.16 measurements against a reference level. Points stream
// in one per cycle while tready is high; a point flagged not_a_number (tuser)
// or with error <= 0 is skipped. The point marked tlast closes the set: input
// then stalls while the threshold products are registered, the restoring
// divider forms the mean deviation at one quotient bit per cycle and the result
// is loaded, and longer if the previous result has not yet been taken. A result
// waiting in the output register does not stall a running set. The user writes
// registers through the cfg port only while no set is in flight; not enforced.
`include "assert_macros.svh"

module reference_deviation_quality_grader
  import rdqg_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,  // value[23:0], error[47:24]
  input  logic                  s_axis_tuser,  // not_a_number
  input  logic                  s_axis_tlast,  // last_point
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // grade[1:0], reason_code[4:2], valid_count[15:5], inside_count[26:16],
  // overlap_count[37:27], mean_deviation[61:38], max_deviation[85:62], zero pad
  output logic [87:0]           m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t cfg;
  cmd_t      cmd;
  stat_t     stat;

  logic [1:0]       grade;
  logic [2:0]       reason_code;
  logic [CNT_W-1:0] valid_count;
  logic [CNT_W-1:0] inside_count;
  logic [CNT_W-1:0] overlap_count;
  logic [VAL_W-1:0] mean_deviation;
  logic [VAL_W-1:0] max_deviation;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reference       <= RESET_REFERENCE;
      cfg.tolerance       <= RESET_TOLERANCE;
      cfg.frac_good       <= RESET_FRAC_GOOD;
      cfg.frac_medium     <= RESET_FRAC_MEDIUM;
      cfg.require_overlap <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REFERENCE:   cfg.reference       <= cfg_data[VAL_W-1:0];
        REG_TOLERANCE:   cfg.tolerance       <= cfg_data[TOL_W-1:0];
        REG_FRAC_GOOD:   cfg.frac_good       <= cfg_data[FRAC_W-1:0];
        REG_FRAC_MEDIUM: cfg.frac_medium     <= cfg_data[FRAC_W-1:0];
        REG_REQ_OVERLAP: cfg.require_overlap <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rdqg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rdqg_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .cfg                (cfg),
    .in_value           (s_axis_tdata[23:0]),
    .in_error           (s_axis_tdata[47:24]),
    .in_not_a_number    (s_axis_tuser),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .out_grade          (grade),
    .out_reason_code    (reason_code),
    .out_valid_count    (valid_count),
    .out_inside_count   (inside_count),
    .out_overlap_count  (overlap_count),
    .out_mean_deviation (mean_deviation),
    .out_max_deviation  (max_deviation)
  );

  assign m_axis_tdata = {2'b00, max_deviation, mean_deviation, overlap_count,
                         inside_count, valid_count, reason_code, grade};

  `ASSERT_NEXT(a_last_stalls, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
  `ASSERT_SAME(a_finish_free, clk, rst, cmd.finish, stat.out_free)
  `ASSERT_SAME(a_accum_alone, clk, rst, cmd.accum, !cmd.load && !cmd.div_step && !cmd.finish)
  `ASSERT_SAME(a_good_no_reason, clk, rst, m_axis_tvalid && (grade == GRADE_GOOD), reason_code == REASON_NONE)

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import rdqg_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES = 45;   // threshold products + divider + result load, with margin
  localparam int REPORT_LINES = 100;
  localparam longint SUM_LIMIT = (64'sd1 <<< SUM_W) - 1;
  localparam longint VAL_MAX = 8388607;
  localparam longint VAL_MIN = -8388608;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    grade_t           grade;
    reason_t          reason;
    logic [CNT_W-1:0] valid_n;
    logic [CNT_W-1:0] inside_n;
    logic [CNT_W-1:0] overlap_n;
    logic [VAL_W-1:0] mean_dev;
    logic [VAL_W-1:0] peak_dev;
  } grading_t;

  class grade_scoreboard;
    logic signed [VAL_W-1:0] reference;
    logic [TOL_W-1:0]        tolerance;
    logic [FRAC_W-1:0]       frac_good;
    logic [FRAC_W-1:0]       frac_medium;
    logic                    require_overlap;
    longint                  n_valid;
    longint                  n_inside;
    longint                  n_overlap;
    longint                  dev_sum;
    longint                  dev_peak;
    grading_t                pending_grades[$];
    int                      errors;

    function new();
      reference = RESET_REFERENCE;
      tolerance = RESET_TOLERANCE;
      frac_good = RESET_FRAC_GOOD;
      frac_medium = RESET_FRAC_MEDIUM;
      require_overlap = 1'b1;
      errors = 0;
      clear_set();
    endfunction

    function void clear_set();
      n_valid = 0;
      n_inside = 0;
      n_overlap = 0;
      dev_sum = 0;
      dev_peak = 0;
    endfunction

    function int pending();
      return pending_grades.size();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_REFERENCE:   reference = data;
        REG_TOLERANCE:   tolerance = data[TOL_W-1:0];
        REG_FRAC_GOOD:   frac_good = data[FRAC_W-1:0];
        REG_FRAC_MEDIUM: frac_medium = data[FRAC_W-1:0];
        REG_REQ_OVERLAP: require_overlap = data[0];
        default: ;
      endcase
    endfunction

    // fraction count/valid below threshold, 65536 = 1.0
    function bit below(longint count, logic [FRAC_W-1:0] thr);
      return count * 65536 < longint'(thr) * n_valid;
    endfunction

    function void note_point(logic signed [VAL_W-1:0] pt_value, logic signed [VAL_W-1:0] pt_error,
                             bit nan, bit last);
      longint   v;
      longint   e;
      longint   r;
      longint   dev;
      longint   mean;
      grading_t g;
      v = pt_value;
      e = pt_error;
      r = reference;
      if (!nan && e > 0 && n_valid < MAX_CHANNELS_DEF) begin
        dev = (v >= r) ? v - r : r - v;
        n_valid++;
        dev_sum += dev;
        if (dev_sum > SUM_LIMIT) dev_sum = SUM_LIMIT;
        if (dev > dev_peak) dev_peak = dev;
        if (dev <= longint'(tolerance) + e) n_inside++;
        if (v - e <= r && r <= v + e) n_overlap++;
      end
      if (!last) return;
      mean = 0;
      if (n_valid == 0) begin
        g.grade = GRADE_NULL;
        g.reason = REASON_NO_VALID;
      end else begin
        mean = dev_sum / n_valid;
        if (mean > 64'hFFFFFF) mean = 64'hFFFFFF;
        if (below(n_inside, frac_medium)) begin
          g.grade = GRADE_BAD;
          g.reason = REASON_BELOW_MEDIUM;
        end else if (below(n_inside, frac_good)) begin
          g.grade = GRADE_MEDIUM;
          g.reason = REASON_BELOW_GOOD;
        end else if (require_overlap && below(n_overlap, frac_good)) begin
          g.grade = GRADE_MEDIUM;
          g.reason = REASON_LOW_OVERLAP;
        end else begin
          g.grade = GRADE_GOOD;
          g.reason = REASON_NONE;
        end
      end
      g.valid_n = n_valid[CNT_W-1:0];
      g.inside_n = n_inside[CNT_W-1:0];
      g.overlap_n = n_overlap[CNT_W-1:0];
      g.mean_dev = mean[VAL_W-1:0];
      g.peak_dev = dev_peak[VAL_W-1:0];
      pending_grades.push_back(g);
      clear_set();
    endfunction

    task report(string msg);
      // keep the log short when the block is badly off
      if (errors < REPORT_LINES) $display("MISMATCH %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [87:0] data);
      grading_t g;
      if (pending_grades.size() == 0) begin
        report($sformatf("unexpected result %h", data));
        return;
      end
      g = pending_grades.pop_front();
      if (data[1:0] !== g.grade)
        report($sformatf("grade %0d, expected %0d", data[1:0], g.grade));
      if (data[4:2] !== g.reason)
        report($sformatf("reason_code %0d, expected %0d", data[4:2], g.reason));
      if (data[15:5] !== g.valid_n)
        report($sformatf("valid_count %0d, expected %0d", data[15:5], g.valid_n));
      if (data[26:16] !== g.inside_n)
        report($sformatf("inside_count %0d, expected %0d", data[26:16], g.inside_n));
      if (data[37:27] !== g.overlap_n)
        report($sformatf("overlap_count %0d, expected %0d", data[37:27], g.overlap_n));
      if (data[61:38] !== g.mean_dev)
        report($sformatf("mean_deviation %0d, expected %0d", data[61:38], g.mean_dev));
      if (data[85:62] !== g.peak_dev)
        report($sformatf("max_deviation %0d, expected %0d", data[85:62], g.peak_dev));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [87:0]           m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  grade_scoreboard sb = new();
  bit calm = 0;
  int idle_cycles = 0;

  reference_deviation_quality_grader u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stall bursts
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("reference_deviation_quality_grader verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [VAL_W-1:0] clamp24(longint x);
    if (x > VAL_MAX) return VAL_MAX[VAL_W-1:0];
    if (x < VAL_MIN) return VAL_MIN[VAL_W-1:0];
    return x[VAL_W-1:0];
  endfunction

  task automatic send_point(logic signed [VAL_W-1:0] pt_value, logic signed [VAL_W-1:0] pt_error,
                            bit nan, bit last);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {pt_error, pt_value};
    s_axis_tuser = nan;
    s_axis_tlast = last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_point(pt_value, pt_error, nan, last);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold off requests until every grade is out and the divider has gone quiet
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(logic [CFG_DATA_W-1:0] ref_lvl, logic [CFG_DATA_W-1:0] tol,
                           logic [CFG_DATA_W-1:0] good, logic [CFG_DATA_W-1:0] med_frac,
                           logic [CFG_DATA_W-1:0] need_overlap);
    drain();
    write_reg(REG_REFERENCE, ref_lvl);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_FRAC_GOOD, good);
    write_reg(REG_FRAC_MEDIUM, med_frac);
    write_reg(REG_REQ_OVERLAP, need_overlap);
  endtask

  task automatic send_random_set(int len, int scale, bit all_nan);
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] e;
    int                      kind;
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
        v = VAL_W'($urandom);
        e = VAL_W'($urandom);
      end else begin
        v = clamp24(longint'(sb.reference) + $urandom_range(0, 2 * scale) - scale);
        if (kind == 1) e = clamp24(-longint'($urandom_range(0, 8388608)));
        else e = VAL_W'($urandom_range(1, scale));
      end
      send_point(v, e, all_nan || $urandom_range(0, 19) == 0, i == len - 1);
    end
  endtask

  task automatic run_random(int items);
    int sent;
    int len;
    int scale;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 4))
        0: scale = 64;
        1: scale = 1024;
        2: scale = 8192;
        3: scale = 65536;
        default: scale = 1 << 20;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 4);
        send_random_set(len, scale, 1'b1);
      end else begin
        len = $urandom_range(1, 16);
        send_random_set(len, scale, 1'b0);
      end
      sent += len;
    end
  endtask

  task automatic run_directed();
    longint r;
    longint t;
    r = sb.reference;
    t = sb.tolerance;
    // set whose only point is not_a_number
    send_point(0, 0, 1, 1);
    // invalid errors, field extremes, last point skipped but still graded
    send_point(VAL_W'(r), 0, 0, 0);
    send_point(VAL_W'(r), -1, 0, 0);
    send_point(VAL_MIN[VAL_W-1:0], VAL_MIN[VAL_W-1:0], 0, 0);
    send_point(VAL_MAX[VAL_W-1:0], VAL_MAX[VAL_W-1:0], 0, 0);
    send_point(VAL_MIN[VAL_W-1:0], 1, 0, 0);
    send_point(VAL_W'(r), 1, 1, 1);
    // inside edge exact and one past, overlap edges exact
    send_point(VAL_W'(r + t + 100), 100, 0, 0);
    send_point(VAL_W'(r + t + 101), 100, 0, 0);
    send_point(VAL_W'(r + 50), 50, 0, 0);
    send_point(VAL_W'(r - 50), 50, 0, 1);
    // all close to the reference, error bars covering it
    send_point(VAL_W'(r), 100, 0, 0);
    send_point(VAL_W'(r + 10), 100, 0, 0);
    send_point(VAL_W'(r - 10), 100, 0, 1);
    // error bars miss the reference
    send_point(VAL_W'(r + 1000), 10, 0, 0);
    send_point(VAL_W'(r + 1000), 10, 0, 0);
    send_point(VAL_W'(r - 1000), 10, 0, 1);
    // widest possible deviations
    send_point(VAL_MIN[VAL_W-1:0], VAL_MAX[VAL_W-1:0], 0, 0);
    send_point(VAL_MAX[VAL_W-1:0], 1, 0, 1);
  endtask

  // more valid points than the block counts
  task automatic run_overlong_set();
    logic signed [VAL_W-1:0] v;
    for (int i = 0; i < MAX_CHANNELS_DEF + 16; i++) begin
      v = clamp24(longint'(sb.reference) + $urandom_range(0, 4000) - 2000);
      send_point(v, VAL_W'($urandom_range(1, 4000)), 0, i == MAX_CHANNELS_DEF + 15);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] good;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    run_random(30);

    write_all(24'h800000, 0, 65536, 0, 1);
    run_directed();
    run_random(30);

    write_all(24'h7FFFFF, 24'h7FFFFF, 131071, 65536, 0);
    run_random(20);
    drain();
    run_random(20);

    write_all(0, 3000, 50000, 30000, 1);
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    run_random(30);
    run_overlong_set();

    repeat (2) begin
      good = CFG_DATA_W'($urandom_range(0, 65536));
      write_all(CFG_DATA_W'($urandom),
                {1'($urandom_range(0, 1)), 23'($urandom_range(0, 20000))}, good,
                CFG_DATA_W'($urandom_range(0, good)), CFG_DATA_W'($urandom_range(0, 1)));
      run_random(30);
    end

    write_all(65536, 6554, 58982, 45875, 1);
    calm = 1;
    run_random(30);

    drain();
    if (sb.errors == 0) begin
      $display("reference_deviation_quality_grader verification clean");
    end else begin
      $display("reference_deviation_quality_grader verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/rdqg_pkg.sv
hw/rtl/rdqg_ctrl.sv
hw/rtl/rdqg_datapath.sv
hw/rtl/reference_deviation_quality_grader.sv
dv/tb.sv
